>>> rtl/core/rotary_encoder_position_tracker_core_macros.svh
// Assertion macros for the rotary encoder position tracker checker.
// Depends on nothing; included by the checker file only.
`ifndef ROTARY_ENCODER_POSITION_TRACKER_CORE_MACROS_SVH
`define ROTARY_ENCODER_POSITION_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define REP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define REP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rep_pkg.sv
// Types and constants for the rotary encoder position tracker.
// Used by the register file, the step logic, the top level and the checker.
package rep_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [2:0] REG_MIN_POSITION      = 3'd0;
    localparam logic [2:0] REG_MAX_POSITION      = 3'd1;
    localparam logic [2:0] REG_STEP_SIZE         = 3'd2;
    localparam logic [2:0] REG_FAST_STEP_SIZE    = 3'd3;
    localparam logic [2:0] REG_WRAP_ENABLE       = 3'd4;
    localparam logic [2:0] REG_REVERSE_DIRECTION = 3'd5;

    localparam logic [15:0] CNT_HALF = 16'h7FFF;
    localparam logic [15:0] RST_MIN_POSITION = 16'h8001;
    localparam logic [15:0] RST_MAX_POSITION = 16'h7FFE;
    localparam logic [14:0] CHANGE_MAX = 15'h3FFF;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_WRITE  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] counter_value;
        logic [15:0] new_position;
    } t_in_item;

    typedef struct packed {
        logic [15:0] position;
        logic [14:0] step_change;
        logic        write_accepted;
    } t_out_item;

    typedef struct packed {
        logic [15:0] min_position;
        logic [15:0] max_position;
        logic [7:0]  step_size;
        logic [7:0]  fast_step_size;
        logic        wrap_enable;
        logic        reverse_direction;
    } t_cfg;

endpackage

>>> rtl/core/rotary_encoder_position_tracker_core.sv
// A result is registered twice: an input transfer enters the input register, then moves to the result register.
// Throughput: one item per cycle while the output is not stalled; the step logic between the two registers sets this.
// While a result waits under stall, the input register takes one more transfer, then stalls.
// Reset (synchronous, active low) empties both registers, clears the position and last count,
// and loads the configuration reset values; the input is stalled while reset is low.
module rotary_encoder_position_tracker_core
    import rep_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic      r_in_vld;
    t_in_item  r_in_item;
    logic      r_out_vld;
    t_out_item r_out_item;
    logic      move;
    logic      in_load;
    t_cfg      cfg;
    t_out_item result;

    rep_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rep_calc u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (move),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign move       = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = !i_rst_n || (r_in_vld && !move);
    assign in_load    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= in_load || (r_in_vld && !move);
            r_out_vld <= move || (r_out_vld && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_item <= i_in_data;
        end
        if (move) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_item;

endmodule

>>> rtl/core/rep_cfg.sv
// Configuration register file behind the APB-style port.
// Depends on rep_pkg for the register codes and the configuration struct.
module rep_cfg
    import rep_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_position      <= RST_MIN_POSITION;
            r_cfg.max_position      <= RST_MAX_POSITION;
            r_cfg.step_size         <= 8'd1;
            r_cfg.fast_step_size    <= 8'd1;
            r_cfg.wrap_enable       <= 1'b0;
            r_cfg.reverse_direction <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MIN_POSITION:      r_cfg.min_position      <= pwdata[15:0];
                REG_MAX_POSITION:      r_cfg.max_position      <= pwdata[15:0];
                REG_STEP_SIZE:         r_cfg.step_size         <= pwdata[7:0];
                REG_FAST_STEP_SIZE:    r_cfg.fast_step_size    <= pwdata[7:0];
                REG_WRAP_ENABLE:       r_cfg.wrap_enable       <= pwdata[0];
                REG_REVERSE_DIRECTION: r_cfg.reverse_direction <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_POSITION:      prdata = {{16{r_cfg.min_position[15]}}, r_cfg.min_position};
            REG_MAX_POSITION:      prdata = {{16{r_cfg.max_position[15]}}, r_cfg.max_position};
            REG_STEP_SIZE:         prdata = {24'd0, r_cfg.step_size};
            REG_FAST_STEP_SIZE:    prdata = {24'd0, r_cfg.fast_step_size};
            REG_WRAP_ENABLE:       prdata = {31'd0, r_cfg.wrap_enable};
            REG_REVERSE_DIRECTION: prdata = {31'd0, r_cfg.reverse_direction};
            default:               prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/rep_calc.sv
// Step logic: counter distance, direction, increment, range handling and the
// tracker state registers. Depends on rep_pkg for the item and config structs.
module rep_calc
    import rep_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic [15:0]        r_last_count;
    logic [15:0]        r_position;
    logic [15:0]        n_last_count;
    logic [15:0]        n_position;

    logic [15:0]        diff;
    logic [15:0]        neg_diff;
    logic               fwd;
    logic [15:0]        span;
    logic [14:0]        half;
    logic               moved;
    logic [7:0]         inc;
    logic               dec;
    logic signed [17:0] pos_w;
    logic signed [17:0] inc_w;
    logic signed [17:0] sum;
    logic signed [17:0] min_w;
    logic signed [17:0] max_w;
    logic signed [17:0] np_w;
    logic               in_range;
    logic [14:0]        change;
    logic               accepted;

    assign diff     = i_item.counter_value - r_last_count;
    assign neg_diff = r_last_count - i_item.counter_value;

    always_comb begin
        if (i_item.counter_value > r_last_count) begin
            fwd = (diff < CNT_HALF);
        end else begin
            fwd = !(neg_diff < CNT_HALF);
        end
        span  = fwd ? diff : neg_diff;
        half  = span[15:1];
        moved = (half != 15'd0);
        if (half > 15'd1) begin
            inc = (i_cfg.fast_step_size != 8'd0) ? i_cfg.fast_step_size : half[7:0];
        end else begin
            inc = i_cfg.step_size;
        end
        dec = (fwd == i_cfg.reverse_direction);
    end

    assign pos_w = $signed({{2{r_position[15]}}, r_position});
    assign inc_w = $signed({10'd0, inc});
    assign min_w = $signed({{2{i_cfg.min_position[15]}}, i_cfg.min_position});
    assign max_w = $signed({{2{i_cfg.max_position[15]}}, i_cfg.max_position});
    assign np_w  = $signed({{2{i_item.new_position[15]}}, i_item.new_position});
    assign sum   = dec ? (pos_w - inc_w) : (pos_w + inc_w);
    assign in_range = (np_w >= min_w) && (np_w <= max_w);

    always_comb begin
        n_position   = r_position;
        n_last_count = r_last_count;
        change       = 15'd0;
        accepted     = 1'b0;
        if (i_item.req_type == REQ_WRITE) begin
            if (in_range) begin
                n_position = i_item.new_position;
                accepted   = 1'b1;
            end
        end else if (moved) begin
            n_last_count = i_item.counter_value;
            if (sum > max_w) begin
                n_position = i_cfg.wrap_enable ? i_cfg.min_position : i_cfg.max_position;
            end else if (sum < min_w) begin
                n_position = i_cfg.wrap_enable ? i_cfg.max_position : i_cfg.min_position;
            end else begin
                n_position = sum[15:0];
            end
            if (dec) begin
                change = ~half + 15'd1;
            end else begin
                change = half[14] ? CHANGE_MAX : half;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_count <= '0;
            r_position   <= '0;
        end else if (i_fire) begin
            r_last_count <= n_last_count;
            r_position   <= n_position;
        end
    end

    assign o_result.position       = n_position;
    assign o_result.step_change    = change;
    assign o_result.write_accepted = accepted;

endmodule

>>> rtl/core/rep_chk.sv
// Port-level checker for the rotary encoder position tracker, with its bind.
// Depends on rep_pkg and on the assertion macros header.
`include "rotary_encoder_position_tracker_core_macros.svh"

module rep_chk
    import rep_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input t_in_item              i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_out_data,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [CFG_ADDR_W-1:0] paddr,
    input logic [CFG_DATA_W-1:0] pwdata,
    input logic [CFG_DATA_W-1:0] prdata,
    input logic                  pready
);

    // The input side stalls only when a result is waiting and held back.
    `REP_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled without a blocked result")

    // A result that appears on an empty output comes from an input transfer held in the input register.
    `REP_ASSERT_NOW(a_out_origin, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && !o_in_stall, 2), "result without a matching input transfer")

    // A held result keeps its value.
    `REP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

    // An applied write never reports movement.
    `REP_ASSERT_NOW(a_write_no_step, i_clk, i_rst_n, o_out_valid && o_out_data.write_accepted, o_out_data.step_change == 15'd0, "write result with nonzero step change")

endmodule

bind rotary_encoder_position_tracker_core rep_chk u_rep_chk (.*);
